// File: rtl/core/station_mac_table_assert.svh
// assertion macros shared by the station table rtl
// expects signals named clock and reset in the scope of each use
`ifndef STATION_MAC_TABLE_ASSERT_SVH
`define STATION_MAC_TABLE_ASSERT_SVH
`ifndef ASSERT_OFF
// checked property, disabled while reset is high
`define SMT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// checked property, also watched during reset
`define SMT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define SMT_ASSERT(lbl, prop, msg)
`define SMT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: rtl/core/smt_pkg.sv
// shared types and codes for the station mac table
// no dependencies
package smt_pkg;

   localparam int TABLE_ENTRIES = 32;

   // function codes
   localparam logic [2:0] FN_ADD     = 3'd0;
   localparam logic [2:0] FN_LOOKUP  = 3'd1;
   localparam logic [2:0] FN_DEL_STA = 3'd2;
   localparam logic [2:0] FN_DEL_EXT = 3'd3;
   localparam logic [2:0] FN_CLEAR   = 3'd4;

   // status codes
   localparam logic [1:0] STS_OK        = 2'd0;
   localparam logic [1:0] STS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STS_FULL      = 2'd2;

   typedef struct packed {
      logic [2:0]  func;
      logic [47:0] station_mac;
      logic [47:0] extender_mac;
      logic [7:0]  connection_type;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic       found;
   } rsp_type;

   // per-cell update strobes
   typedef struct packed {
      logic write;
      logic kill;
   } cell_ctl_type;

   // per-cell registered compare flags
   typedef struct packed {
      logic valid;
      logic sta_hit;
      logic ext_hit;
      logic pair_hit;
   } cell_stat_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CMP,
      S_APPLY
   } state_type;

endpackage

// File: rtl/core/station_mac_table.sv
// top level of the station mac table: control sequencer, row of cells, result register
// depends on smt_pkg, smt_cell, smt_pick and the assertion header
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_data  (func, station_mac, extender_mac, type)
//   rsp      out        rsp_valid / rsp_ready  rsp_data  (status, found)
//
// each item passes through accept, compare in every cell, apply and register the result
// the item rate is set by the sequencer, one item in flight through the row of cells
// reset empties the table at once by clearing all valid bits; no sweep is needed
// a result waiting on rsp does not block accepting the next item; only its apply
// cycle waits until the result register is free
`include "station_mac_table_assert.svh"
module station_mac_table (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  smt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output smt_pkg::rsp_type rsp_data
);
   import smt_pkg::*;

   state_type state_ff, state_in;
   req_type   cmd_ff;
   logic      rsp_valid_ff;
   rsp_type   rsp_data_ff;
   rsp_type   result;
   logic      apply_go, apply_en;

   cell_stat_type [TABLE_ENTRIES-1:0] stat;
   cell_ctl_type  [TABLE_ENTRIES-1:0] ctl;

   assign apply_go = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_valid) state_in = S_CMP;
         S_CMP:   state_in = S_APPLY;
         S_APPLY: if (apply_go) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      apply_en  = 1'b0;
      case (state_ff)
         S_IDLE:  req_ready = 1'b1;
         S_CMP:   req_ready = 1'b0;
         S_APPLY: apply_en  = apply_go;
         default: req_ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // command broadcast register
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff <= req_data;
      end
   end

   // row of table cells
   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      smt_cell u_cell (
         .clock (clock),
         .reset (reset),
         .cmd   (cmd_ff),
         .ctl   (ctl[g]),
         .stat  (stat[g])
      );
   end

   smt_pick u_pick (
      .clock    (clock),
      .reset    (reset),
      .func     (cmd_ff.func),
      .apply_en (apply_en),
      .stat     (stat),
      .ctl      (ctl),
      .result   (result)
   );

   // result beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (apply_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (apply_en) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SMT_ASSERT(a_apply_rsp, apply_en |=> rsp_valid, "applied item gave no result beat")
   `SMT_ASSERT(a_found_ok, rsp_valid |-> !(rsp_data.found && rsp_data.status != STS_OK), "found with bad status")
   `SMT_ASSERT(a_accept_cmp, (req_valid && req_ready) |=> state_ff == S_CMP, "accepted beat not compared")

endmodule

// File: rtl/core/smt_cell.sv
// one table entry with its own comparators and registered hit flags
// depends on smt_pkg
module smt_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  smt_pkg::req_type     cmd,
   input  smt_pkg::cell_ctl_type ctl,
   output smt_pkg::cell_stat_type stat
);
   import smt_pkg::*;

   logic        valid_ff;
   logic [47:0] sta_ff;
   logic [47:0] ext_ff;
   logic [7:0]  ctype_ff;
   logic        sta_hit_ff, ext_hit_ff, pair_hit_ff;
   logic        sta_hit_in, ext_hit_in;

   // entry valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.write) begin
         valid_ff <= 1'b1;
      end else if (ctl.kill) begin
         valid_ff <= 1'b0;
      end
   end

   // entry payload, loaded on write
   always_ff @(posedge clock) begin
      if (ctl.write) begin
         sta_ff   <= cmd.station_mac;
         ext_ff   <= cmd.extender_mac;
         ctype_ff <= cmd.connection_type;
      end
   end

   // key compares against the broadcast command
   assign sta_hit_in = valid_ff && (sta_ff == cmd.station_mac);
   assign ext_hit_in = valid_ff && (ext_ff == cmd.extender_mac);

   always_ff @(posedge clock) begin
      sta_hit_ff  <= sta_hit_in;
      ext_hit_ff  <= ext_hit_in;
      pair_hit_ff <= sta_hit_in && ext_hit_in;
   end

   assign stat.valid    = valid_ff;
   assign stat.sta_hit  = sta_hit_ff;
   assign stat.ext_hit  = ext_hit_ff;
   assign stat.pair_hit = pair_hit_ff;

endmodule

// File: rtl/core/smt_pick.sv
// reduces the cell flags, picks the lowest free cell and builds the result
// depends on smt_pkg and the assertion header
`include "station_mac_table_assert.svh"
module smt_pick (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic [2:0]                                    func,
   input  logic                                          apply_en,
   input  smt_pkg::cell_stat_type [smt_pkg::TABLE_ENTRIES-1:0] stat,
   output smt_pkg::cell_ctl_type  [smt_pkg::TABLE_ENTRIES-1:0] ctl,
   output smt_pkg::rsp_type                              result
);
   import smt_pkg::*;

   logic [TABLE_ENTRIES-1:0] valid_vec, sta_vec, ext_vec, pair_vec;
   logic [TABLE_ENTRIES-1:0] free_vec, grant_vec;
   logic [TABLE_ENTRIES-1:0] write_vec, kill_vec;

   // gather flags from the row of cells
   always_comb begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         valid_vec[i] = stat[i].valid;
         sta_vec[i]   = stat[i].sta_hit;
         ext_vec[i]   = stat[i].ext_hit;
         pair_vec[i]  = stat[i].pair_hit;
      end
   end

   // lowest free cell as a one-hot grant
   assign free_vec  = ~valid_vec;
   assign grant_vec = free_vec & (~free_vec + {{(TABLE_ENTRIES-1){1'b0}}, 1'b1});

   // decode the function into strobes and result
   always_comb begin
      write_vec     = '0;
      kill_vec      = '0;
      result.status = STS_OK;
      result.found  = 1'b0;
      case (func)
         FN_ADD: begin
            if (|sta_vec) begin
               result.status = STS_OK;
            end else if (!(|free_vec)) begin
               result.status = STS_FULL;
            end else begin
               write_vec = grant_vec;
            end
         end
         FN_LOOKUP: begin
            result.found = |pair_vec;
         end
         FN_DEL_STA: begin
            kill_vec      = sta_vec;
            result.status = (|sta_vec) ? STS_OK : STS_NOT_FOUND;
         end
         FN_DEL_EXT: begin
            kill_vec      = ext_vec;
            result.status = (|ext_vec) ? STS_OK : STS_NOT_FOUND;
         end
         FN_CLEAR: begin
            kill_vec = '1;
         end
         default: begin
            result.status = STS_OK;
         end
      endcase
   end

   // strobes reach the cells only in the apply cycle
   always_comb begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         ctl[i].write = apply_en && write_vec[i];
         ctl[i].kill  = apply_en && kill_vec[i];
      end
   end

   `SMT_ASSERT_ALWAYS(a_grant_onehot, $onehot0(grant_vec), "more than one free cell granted")
   `SMT_ASSERT(a_write_free, (write_vec & valid_vec) == '0, "add targets an occupied cell")
   `SMT_ASSERT(a_strobe_apply, (|ctl) |-> apply_en, "cell strobe outside apply cycle")

endmodule

// File: test/tb_station_mac_table.sv
// testbench for station_mac_table: random and directed table commands checked against a
// predictor of the table that runs inside a small scoreboard class
// depends on smt_pkg and the station_mac_table rtl
`timescale 1ns / 1ps

module tb_station_mac_table;
   import smt_pkg::*;

   localparam int TOTAL_BEATS = 1400;
   localparam int STA_POOL = 40;
   localparam int EXT_POOL = 8;
   localparam int LONG_HOLD = 400;
   localparam int SETTLE_CYCLES = 8;
   localparam logic [47:0] MAC_ONES = 48'hFFFF_FFFF_FFFF;
   localparam logic [47:0] MAC_ZERO = 48'h0;
   localparam logic [2:0] FN_SPARE_LO = 3'd5;
   localparam logic [2:0] FN_SPARE_MID = 3'd6;
   localparam logic [2:0] FN_SPARE_HI = 3'd7;

   // predictor of the table contents and queue of results it expects
   class station_table_scoreboard;
      bit          slot_valid [TABLE_ENTRIES];
      logic [47:0] slot_sta [TABLE_ENTRIES];
      logic [47:0] slot_ext [TABLE_ENTRIES];
      logic [7:0]  slot_ctype [TABLE_ENTRIES];
      rsp_type     pending_results [$];
      int          failures;
      int          results_seen;

      function void flag_mismatch(string what);
         failures++;
         if (failures <= 10)
            $display("mismatch at result %0d: %s", results_seen, what);
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      // apply one accepted command to the table and queue its result
      function void note_request(req_type r);
         rsp_type res;
         int free_slot;
         bit hit;
         res.status = STS_OK;
         res.found = 1'b0;
         free_slot = -1;
         hit = 1'b0;
         case (r.func)
            FN_ADD: begin
               for (int i = 0; i < TABLE_ENTRIES; i++) begin
                  if (slot_valid[i]) begin
                     if (slot_sta[i] == r.station_mac) hit = 1'b1;
                  end else if (free_slot < 0) begin
                     free_slot = i;
                  end
               end
               // duplicate station leaves the table alone
               if (!hit) begin
                  if (free_slot < 0) begin
                     res.status = STS_FULL;
                  end else begin
                     slot_valid[free_slot] = 1'b1;
                     slot_sta[free_slot] = r.station_mac;
                     slot_ext[free_slot] = r.extender_mac;
                     slot_ctype[free_slot] = r.connection_type;
                  end
               end
            end
            FN_LOOKUP: begin
               for (int i = 0; i < TABLE_ENTRIES; i++)
                  if (slot_valid[i] && slot_sta[i] == r.station_mac &&
                      slot_ext[i] == r.extender_mac)
                     res.found = 1'b1;
            end
            FN_DEL_STA: begin
               for (int i = 0; i < TABLE_ENTRIES; i++)
                  if (slot_valid[i] && slot_sta[i] == r.station_mac) begin
                     slot_valid[i] = 1'b0;
                     hit = 1'b1;
                  end
               if (!hit) res.status = STS_NOT_FOUND;
            end
            FN_DEL_EXT: begin
               for (int i = 0; i < TABLE_ENTRIES; i++)
                  if (slot_valid[i] && slot_ext[i] == r.extender_mac) begin
                     slot_valid[i] = 1'b0;
                     hit = 1'b1;
                  end
               if (!hit) res.status = STS_NOT_FOUND;
            end
            FN_CLEAR: begin
               for (int i = 0; i < TABLE_ENTRIES; i++) slot_valid[i] = 1'b0;
            end
            default: ;
         endcase
         pending_results.push_back(res);
      endfunction

      // compare one result beat with the oldest expectation
      function void check_response(rsp_type got);
         rsp_type want;
         results_seen++;
         if (pending_results.size() == 0) begin
            flag_mismatch($sformatf("unexpected result status %0d found %0d",
                                    got.status, got.found));
            return;
         end
         want = pending_results.pop_front();
         if (got.status !== want.status)
            flag_mismatch($sformatf("status expected %0d got %0d", want.status, got.status));
         if (got.found !== want.found)
            flag_mismatch($sformatf("found expected %0d got %0d", want.found, got.found));
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   station_table_scoreboard sb = new();
   bit          idling_on = 1'b1;
   bit          stall_receiver = 1'b0;
   int          beats_sent = 0;
   logic [47:0] sta_pool [STA_POOL];
   logic [47:0] ext_pool [EXT_POOL];

   station_mac_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("FAILURE");
      $finish;
   end

   // watch both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
         if (req_valid && req_ready) sb.note_request(req_data);
      end
   end

   // result side: random back-pressure plus a long hold each time one is requested
   initial begin : result_sink
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (stall_receiver) begin
            stall_receiver = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !(idling_on && $urandom_range(99) < 19);
         end
      end
   end

   function automatic logic [47:0] random_mac();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[47:0];
   endfunction

   function automatic req_type make_beat(logic [2:0] f, logic [47:0] sta, logic [47:0] ext,
                                         logic [7:0] ctype);
      req_type r;
      r.func = f;
      r.station_mac = sta;
      r.extender_mac = ext;
      r.connection_type = ctype;
      return r;
   endfunction

   // offer one beat after an optional random gap, return once accepted
   task automatic send_beat(req_type item);
      while (idling_on && $urandom_range(99) < 19) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
   endtask

   // drop valid and hold off until every result is back
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // fresh stations added in a burst that can overflow the table, sometimes after a clear
   task automatic fill_burst();
      int n;
      n = $urandom_range(30, 36);
      if ($urandom_range(1) == 0) send_beat(make_beat(FN_CLEAR, random_mac(), random_mac(),
                                                      8'($urandom)));
      for (int i = 0; i < n; i++)
         send_beat(make_beat(FN_ADD, random_mac(), ext_pool[$urandom_range(EXT_POOL - 1)],
                             8'($urandom)));
   endtask

   // mixed commands over small mac pools so keys collide often
   task automatic mixed_run(int n);
      int pick;
      int idx;
      logic [47:0] ext;
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(99);
         idx = $urandom_range(STA_POOL - 1);
         ext = ($urandom_range(3) != 0) ? ext_pool[idx % EXT_POOL]
                                        : ext_pool[$urandom_range(EXT_POOL - 1)];
         if (pick < 38)
            send_beat(make_beat(FN_ADD, sta_pool[idx], ext, 8'($urandom)));
         else if (pick < 62)
            send_beat(make_beat(FN_LOOKUP, sta_pool[idx], ext, 8'($urandom)));
         else if (pick < 74)
            send_beat(make_beat(FN_DEL_STA, sta_pool[idx], random_mac(), 8'($urandom)));
         else if (pick < 82)
            send_beat(make_beat(FN_DEL_EXT, random_mac(), ext, 8'($urandom)));
         else if (pick < 85)
            send_beat(make_beat(FN_CLEAR, random_mac(), random_mac(), 8'($urandom)));
         else if (pick < 89)
            send_beat(make_beat(3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI)), random_mac(),
                                random_mac(), 8'($urandom)));
         else
            send_beat(make_beat(3'($urandom_range(FN_SPARE_HI)), random_mac(), random_mac(),
                                8'($urandom)));
      end
   endtask

   initial begin : stimulus
      int episode;
      logic [47:0] mac_a;
      logic [47:0] mac_b;
      episode = 0;
      mac_a = random_mac();
      mac_b = random_mac();
      for (int i = 0; i < STA_POOL; i++) sta_pool[i] = random_mac();
      for (int i = 0; i < EXT_POOL; i++) ext_pool[i] = random_mac();

      // hold synchronous reset, then release it
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty table, extremes, duplicate add, multi-entry delete, spare codes
      send_beat(make_beat(FN_LOOKUP, MAC_ZERO, MAC_ZERO, 8'h00));
      send_beat(make_beat(FN_DEL_STA, MAC_ZERO, MAC_ONES, 8'hFF));
      send_beat(make_beat(FN_DEL_EXT, MAC_ONES, MAC_ONES, 8'h00));
      send_beat(make_beat(FN_ADD, MAC_ZERO, MAC_ONES, 8'h00));
      send_beat(make_beat(FN_ADD, MAC_ONES, MAC_ZERO, 8'hFF));
      send_beat(make_beat(FN_ADD, MAC_ZERO, mac_a, 8'h5A));
      send_beat(make_beat(FN_LOOKUP, MAC_ZERO, MAC_ONES, 8'h00));
      send_beat(make_beat(FN_LOOKUP, MAC_ZERO, mac_a, 8'h00));
      send_beat(make_beat(FN_LOOKUP, MAC_ONES, MAC_ZERO, 8'h00));
      send_beat(make_beat(FN_ADD, mac_a, MAC_ONES, 8'h3C));
      send_beat(make_beat(FN_DEL_EXT, MAC_ZERO, MAC_ONES, 8'h00));
      send_beat(make_beat(FN_LOOKUP, MAC_ZERO, MAC_ONES, 8'h00));
      send_beat(make_beat(FN_DEL_STA, mac_a, MAC_ZERO, 8'h00));
      send_beat(make_beat(FN_DEL_STA, MAC_ONES, MAC_ZERO, 8'h00));
      send_beat(make_beat(FN_SPARE_LO, MAC_ONES, MAC_ONES, 8'hFF));
      send_beat(make_beat(FN_SPARE_MID, mac_a, mac_b, 8'hA5));
      send_beat(make_beat(FN_SPARE_HI, MAC_ZERO, MAC_ZERO, 8'h00));
      send_beat(make_beat(FN_ADD, mac_b, mac_a, 8'h00));
      send_beat(make_beat(FN_CLEAR, MAC_ONES, MAC_ONES, 8'hFF));
      send_beat(make_beat(FN_LOOKUP, mac_b, mac_a, 8'h00));
      send_beat(make_beat(FN_CLEAR, MAC_ZERO, MAC_ZERO, 8'h00));
      send_beat(make_beat(FN_LOOKUP, MAC_ONES, MAC_ONES, 8'hFF));

      // random episodes
      while (beats_sent < TOTAL_BEATS) begin
         episode++;
         idling_on = !(episode >= 10 && episode <= 16);
         if (episode == 5 || episode == 25) stall_receiver = 1'b1;
         if (episode % 9 == 0) wait_for_drain();
         if ($urandom_range(3) == 0) fill_burst();
         else mixed_run($urandom_range(20, 60));
      end

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
